[hdl/cjk_pkg.sv]
// ---------------------------------------------------------------------------
// cjk_pkg: shared types and constants of the CJK to MULE converter
// Encoding and character kind codes, charset bytes and the burst record
// that travels from the front end to the output serializer.
// ---------------------------------------------------------------------------
package cjk_pkg;

   // most bytes one source byte can cause (four for a CNS plane char + terminator)
   localparam int BURST_MAX   = 5;
   localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);
   localparam int BURST_IDX_W = $clog2(BURST_MAX);

   // burst queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // source encodings selected by the mode register
   typedef enum logic [2:0] {
      ENC_SJIS   = 3'd0,
      ENC_EUC_JP = 3'd1,
      ENC_EUC_KR = 3'd2,
      ENC_EUC_CN = 3'd3,
      ENC_EUC_TW = 3'd4,
      ENC_LATIN1 = 3'd5,
      ENC_RSVD6  = 3'd6,
      ENC_RSVD7  = 3'd7
   } encoding_type;

   // kind of the multibyte character in progress
   typedef enum logic [2:0] {
      KIND_SJIS  = 3'd0,
      KIND_KANA  = 3'd1,
      KIND_X0212 = 3'd2,
      KIND_X0208 = 3'd3,
      KIND_KR    = 3'd4,
      KIND_CN    = 3'd5,
      KIND_TW2   = 3'd6,
      KIND_TW4   = 3'd7
   } kind_type;

   // leading charset bytes
   localparam logic [7:0] LC_LATIN1  = 8'h81;
   localparam logic [7:0] LC_KANA    = 8'h89;
   localparam logic [7:0] LC_GB2312  = 8'h91;
   localparam logic [7:0] LC_X0208   = 8'h92;
   localparam logic [7:0] LC_KSC5601 = 8'h93;
   localparam logic [7:0] LC_X0212   = 8'h94;
   localparam logic [7:0] LC_CNS1    = 8'h95;
   localparam logic [7:0] LC_CNS2    = 8'h96;
   localparam logic [7:0] LC_PRIV    = 8'h9d;
   // plane byte = plane - 0xa3 + 0xf6, i.e. plane + 0x53 modulo 256
   localparam logic [7:0] PLANE_OFS  = 8'h53;

   // source byte values
   localparam logic [7:0] SS2        = 8'h8e;
   localparam logic [7:0] SS3        = 8'h8f;
   localparam logic [7:0] PLANE1     = 8'ha1;
   localparam logic [7:0] PLANE2     = 8'ha2;
   localparam logic [7:0] KANA_LO    = 8'ha1;
   localparam logic [7:0] KANA_HI    = 8'hdf;
   localparam logic [7:0] ASCII_MAX  = 8'h7f;
   localparam logic [7:0] SJIS_SPLIT = 8'h9e;
   localparam logic [7:0] SJIS_HI_OF = 8'h9f;
   localparam logic [7:0] SJIS_LO_A  = 8'h02;
   localparam logic [7:0] SJIS_LO_B  = 8'h60;
   localparam logic [7:0] SJIS_GAP   = 8'h80;

   // result bytes caused by one accepted source byte
   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] bytes;
      logic [BURST_CNT_W-1:0]    count;   // 1 .. BURST_MAX
      logic                      term;    // last byte is the string terminator
   } burst_type;

endpackage

[hdl/cjk_if.sv]
// ---------------------------------------------------------------------------
// cjk_req_if / cjk_rsp_if: valid/ready channels of the converter
// Source byte channel and MULE byte channel, each with both modports.
// ---------------------------------------------------------------------------
interface cjk_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cjk_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] mic_byte;
   logic       run_last;
   logic       string_end;

   modport source (output valid, output mic_byte, output run_last, output string_end,
                   input ready);
   modport sink   (input valid, input mic_byte, input run_last, input string_end,
                   output ready);
endinterface

[hdl/cjk_front.sv]
// ---------------------------------------------------------------------------
// cjk_front: byte classifier and character assembler
// Holds the mode register and the partial character, and turns each
// accepted source byte into a burst of MULE internal code bytes.
// ---------------------------------------------------------------------------
module cjk_front
   import cjk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_write_data,
   input  logic       in_valid,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic       space_ok,
   output logic       in_ready,
   output logic       push,
   output burst_type  burst
);

   encoding_type encoding_ff;
   logic [1:0]   pending_count_ff, pending_count_in;
   kind_type     char_kind_ff, char_kind_in;
   logic [7:0]   first_held_ff, first_held_in;
   logic [7:0]   second_held_ff, second_held_in;

   logic         transfer;

   assign in_ready = space_ok;
   assign transfer = in_valid && space_ok;

   // classify the byte, build the burst and the next character state
   always_comb begin
      logic [3:0][7:0] cb;       // character bytes
      logic [2:0]      cn;       // number of character bytes
      logic            gt;
      logic [7:0]      hi;
      logic [7:0]      lo;
      logic            close;

      cb               = '0;
      cn               = 3'd0;
      pending_count_in = pending_count_ff;
      char_kind_in     = char_kind_ff;
      first_held_in    = first_held_ff;
      second_held_in   = second_held_ff;

      // SJIS kanji remap
      gt = (in_byte > SJIS_SPLIT);
      hi = {1'b0, first_held_ff[5:0], 1'b0} + SJIS_HI_OF + {7'd0, gt};
      lo = in_byte + (gt ? SJIS_LO_A : SJIS_LO_B) + {7'd0, (in_byte < SJIS_GAP)};

      if (in_byte != 8'd0) begin
         if (pending_count_ff == 2'd0) begin
            // lead byte
            unique case (encoding_ff) inside
               ENC_SJIS: begin
                  if (in_byte >= KANA_LO && in_byte <= KANA_HI) begin
                     cb[0] = LC_KANA; cb[1] = in_byte; cn = 3'd2;
                  end else if (in_byte > ASCII_MAX) begin
                     char_kind_in = KIND_SJIS; first_held_in = in_byte;
                     pending_count_in = 2'd1;
                  end else begin
                     cb[0] = in_byte; cn = 3'd1;
                  end
               end
               ENC_EUC_JP: begin
                  if (in_byte == SS2) begin
                     char_kind_in = KIND_KANA; first_held_in = 8'd0;
                     pending_count_in = 2'd1;
                  end else if (in_byte == SS3) begin
                     char_kind_in = KIND_X0212; first_held_in = 8'd0;
                     pending_count_in = 2'd1;
                  end else if (in_byte[7]) begin
                     char_kind_in = KIND_X0208; first_held_in = in_byte;
                     pending_count_in = 2'd1;
                  end else begin
                     cb[0] = in_byte; cn = 3'd1;
                  end
               end
               ENC_EUC_KR, ENC_EUC_CN: begin
                  if (in_byte[7]) begin
                     char_kind_in = (encoding_ff == ENC_EUC_KR) ? KIND_KR : KIND_CN;
                     first_held_in = in_byte;
                     pending_count_in = 2'd1;
                  end else begin
                     cb[0] = in_byte; cn = 3'd1;
                  end
               end
               ENC_EUC_TW: begin
                  if (in_byte == SS2) begin
                     char_kind_in = KIND_TW4; first_held_in = 8'd0;
                     pending_count_in = 2'd1;
                  end else if (in_byte[7]) begin
                     char_kind_in = KIND_TW2; first_held_in = in_byte;
                     pending_count_in = 2'd1;
                  end else begin
                     cb[0] = in_byte; cn = 3'd1;
                  end
               end
               default: begin
                  // Latin-1 and the unused codes
                  if (in_byte > ASCII_MAX) begin
                     cb[0] = LC_LATIN1; cb[1] = in_byte; cn = 3'd2;
                  end else begin
                     cb[0] = in_byte; cn = 3'd1;
                  end
               end
            endcase
         end else begin
            // trailing byte of the character in progress
            pending_count_in = 2'd0;
            unique case (char_kind_ff)
               KIND_SJIS: begin
                  cb[0] = LC_X0208; cb[1] = hi; cb[2] = lo; cn = 3'd3;
               end
               KIND_KANA: begin
                  cb[0] = LC_KANA; cb[1] = in_byte; cn = 3'd2;
               end
               KIND_X0212: begin
                  if (pending_count_ff == 2'd1) begin
                     first_held_in = in_byte; pending_count_in = 2'd2;
                  end else begin
                     cb[0] = LC_X0212; cb[1] = first_held_ff; cb[2] = in_byte; cn = 3'd3;
                  end
               end
               KIND_X0208: begin
                  cb[0] = LC_X0208; cb[1] = first_held_ff; cb[2] = in_byte; cn = 3'd3;
               end
               KIND_KR: begin
                  cb[0] = LC_KSC5601; cb[1] = first_held_ff; cb[2] = in_byte; cn = 3'd3;
               end
               KIND_CN: begin
                  cb[0] = LC_GB2312; cb[1] = first_held_ff; cb[2] = in_byte; cn = 3'd3;
               end
               KIND_TW2: begin
                  cb[0] = LC_CNS1; cb[1] = first_held_ff; cb[2] = in_byte; cn = 3'd3;
               end
               KIND_TW4: begin
                  if (pending_count_ff == 2'd1) begin
                     first_held_in = in_byte; pending_count_in = 2'd2;
                  end else if (pending_count_ff == 2'd2) begin
                     second_held_in = in_byte; pending_count_in = 2'd3;
                  end else if (first_held_ff == PLANE1) begin
                     cb[0] = LC_CNS1; cb[1] = second_held_ff; cb[2] = in_byte; cn = 3'd3;
                  end else if (first_held_ff == PLANE2) begin
                     cb[0] = LC_CNS2; cb[1] = second_held_ff; cb[2] = in_byte; cn = 3'd3;
                  end else begin
                     cb[0] = LC_PRIV; cb[1] = first_held_ff + PLANE_OFS;
                     cb[2] = second_held_ff; cb[3] = in_byte; cn = 3'd4;
                  end
               end
               default: begin
                  cn = 3'd0;
               end
            endcase
         end
      end

      // end of string: drop any partial char, append terminator
      close = (in_byte == 8'd0) || in_last;
      if (close) begin
         pending_count_in = 2'd0;
         char_kind_in     = KIND_SJIS;
         first_held_in    = 8'd0;
         second_held_in   = 8'd0;
      end

      burst.bytes = {8'd0, cb};
      burst.count = BURST_CNT_W'(cn) + BURST_CNT_W'(close);
      burst.term  = close;
   end

   assign push = transfer && (burst.count != '0);

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         encoding_ff <= ENC_SJIS;
      end else if (csr_write_enable) begin
         encoding_ff <= encoding_type'(csr_write_data);
      end
   end

   // character state
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_count_ff <= 2'd0;
         char_kind_ff     <= KIND_SJIS;
         first_held_ff    <= 8'd0;
         second_held_ff   <= 8'd0;
      end else if (transfer) begin
         pending_count_ff <= pending_count_in;
         char_kind_ff     <= char_kind_in;
         first_held_ff    <= first_held_in;
         second_held_ff   <= second_held_in;
      end
   end

endmodule

[hdl/cjk_queue.sv]
// ---------------------------------------------------------------------------
// cjk_queue: burst queue between front end and serializer
// Small register FIFO of burst records; head is read straight from storage.
// ---------------------------------------------------------------------------
module cjk_queue
   import cjk_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  burst_type push_data,
   input  logic      pop,
   output logic      not_full,
   output logic      not_empty,
   output burst_type head
);

   burst_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;

   assign not_full  = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
      end
   end

endmodule

[hdl/cjk_back.sv]
// ---------------------------------------------------------------------------
// cjk_back: burst serializer
// Walks the head burst one byte per transfer and pops it after its last byte.
// ---------------------------------------------------------------------------
module cjk_back
   import cjk_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  burst_type      head,
   output logic           pop,
   cjk_rsp_if.source      rsp_if
);

   logic [BURST_IDX_W-1:0] idx_ff, idx_in;
   logic                   at_last;
   logic                   transfer;

   assign at_last  = (BURST_CNT_W'(idx_ff) + 1'b1 == head.count);
   assign transfer = rsp_if.valid && rsp_if.ready;
   assign pop      = transfer && at_last;

   // output byte straight from the queue head
   assign rsp_if.valid      = head_valid;
   assign rsp_if.mic_byte   = head.bytes[idx_ff];
   assign rsp_if.run_last   = at_last;
   assign rsp_if.string_end = at_last && head.term;

   // byte index within the head burst
   always_comb begin
      idx_in = idx_ff;
      if (transfer) begin
         idx_in = at_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[hdl/cjk_to_mule_internal_converter.sv]
// ---------------------------------------------------------------------------
// cjk_to_mule_internal_converter: SJIS/EUC/Latin-1 to MULE internal code
// Front end assembles characters, a burst queue decouples it from the
// byte serializer that drives the result channel.
// ---------------------------------------------------------------------------
//  channel  dir  payload                                 transfer when
//  req_if   in   data_byte[7:0], last_byte               valid && ready
//  rsp_if   out  mic_byte[7:0], run_last, string_end     valid && ready
//  csr_*    in   csr_write_data[2:0] (source encoding)   csr_write_enable
//
//  One source byte is taken per cycle while the four-entry burst queue has
//  room; each byte's results (up to five) leave one per cycle while rsp_if is
//  ready, so output bandwidth of one byte per cycle sets the sustained rate.
//  Reset is synchronous; it empties the queue and clears the character.
//  The input stalls only when the queue is full; the output stalls freely.
// ---------------------------------------------------------------------------
module cjk_to_mule_internal_converter
   import cjk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_write_data,
   cjk_req_if.sink    req_if,
   cjk_rsp_if.source  rsp_if
);

   logic      push;
   logic      pop;
   logic      not_full;
   logic      not_empty;
   burst_type push_burst;
   burst_type head_burst;

   cjk_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .in_valid         (req_if.valid),
      .in_byte          (req_if.data_byte),
      .in_last          (req_if.last_byte),
      .space_ok         (not_full),
      .in_ready         (req_if.ready),
      .push             (push),
      .burst            (push_burst)
   );

   cjk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_burst),
      .pop       (pop),
      .not_full  (not_full),
      .not_empty (not_empty),
      .head      (head_burst)
   );

   cjk_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (not_empty),
      .head       (head_burst),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

[hdl/cjk_checker.sv]
// ---------------------------------------------------------------------------
// cjk_checker: port-level checks of the converter
// Watches the top-level channels; bound to the top level below.
// ---------------------------------------------------------------------------
module cjk_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_data_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_mic_byte,
   input logic       rsp_run_last,
   input logic       rsp_string_end
);

   // nothing to send right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // terminator is a zero byte that closes its run
   a_term_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_last && rsp_mic_byte == 8'd0)
      else $error("terminator not a closing zero byte");

   // a zero source byte always leaves a terminator queued
   a_zero_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data_byte == 8'd0 |=> rsp_valid)
      else $error("zero byte produced no result");

   // input back-pressure only while results are waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with nothing to send");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mic_byte))
      else $error("stalled result changed");

endmodule

bind cjk_to_mule_internal_converter cjk_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .req_data_byte  (req_if.data_byte),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_mic_byte   (rsp_if.mic_byte),
   .rsp_run_last   (rsp_if.run_last),
   .rsp_string_end (rsp_if.string_end)
);

[dv/cjk_to_mule_internal_converter_tb.sv]
// ---------------------------------------------------------------------------
// cjk_to_mule_internal_converter_tb: self-checking bench of the MULE converter
// Feeds byte strings in every source encoding through the request channel,
// predicts the MULE byte stream in a local model of the character assembler
// and checks every result transfer against it. Both channels idle at random;
// the encoding is switched between phases, sometimes mid-character.
// ---------------------------------------------------------------------------
module cjk_to_mule_internal_converter_tb;
   import cjk_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_BYTES   = 45;
   localparam int MAX_IDLE      = 16;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } src_byte_type;

   typedef struct {
      logic [7:0] mic;
      logic       run_last;
      logic       str_end;
   } mule_byte_type;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [2:0] csr_write_data;

   cjk_req_if req_ch ();
   cjk_rsp_if rsp_ch ();

   cjk_to_mule_internal_converter i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch)
   );

   // source bytes waiting to be sent, MULE bytes waiting to arrive
   src_byte_type  pend_q[$];
   mule_byte_type mule_exp_q[$];
   mule_byte_type burst_q[$];
   logic [7:0]    char_bytes[$];
   logic [7:0]    str_bytes[$];

   int err_count   = 0;
   int cycle_count = 0;

   // idling control, set per phase
   logic req_idle = 1'b1;
   logic rsp_idle = 1'b1;

   // driver / monitor handshake bookkeeping
   logic req_taken   = 1'b0;
   logic gap_drawn   = 1'b0;
   int   gap_left    = 0;
   logic rsp_taken   = 1'b0;
   logic stall_drawn = 1'b0;
   int   stall_left  = 0;

   // converter model state
   encoding_type enc_mode;
   kind_type     held_kind;
   logic [1:0]   held_cnt;
   logic [7:0]   lead_b;
   logic [7:0]   mid_b;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // converter model
   // ------------------------------------------------------------------
   task automatic emit_mule(input logic [7:0] v, input logic str_end);
      burst_q.push_back('{mic: v, run_last: 1'b0, str_end: str_end});
   endtask

   task automatic hold_lead(input kind_type k, input logic [7:0] v);
      held_kind = k;
      lead_b    = v;
      held_cnt  = 2'd1;
   endtask

   task automatic clear_char();
      held_cnt  = 2'd0;
      held_kind = KIND_SJIS;
      lead_b    = 8'h00;
      mid_b     = 8'h00;
   endtask

   task automatic convert_byte(input logic [7:0] b, input logic last);
      logic [7:0] c1;
      logic [7:0] hi;
      logic [7:0] lo;
      logic       done;
      burst_q.delete();
      if (b != 8'h00) begin
         if (held_cnt == 2'd0) begin
            // lead byte or single byte character
            case (enc_mode)
               ENC_SJIS: begin
                  if (b >= KANA_LO && b <= KANA_HI) begin
                     emit_mule(LC_KANA, 1'b0);
                     emit_mule(b, 1'b0);
                  end else if (b > ASCII_MAX) hold_lead(KIND_SJIS, b);
                  else emit_mule(b, 1'b0);
               end
               ENC_EUC_JP: begin
                  if (b == SS2) hold_lead(KIND_KANA, 8'h00);
                  else if (b == SS3) hold_lead(KIND_X0212, 8'h00);
                  else if (b[7]) hold_lead(KIND_X0208, b);
                  else emit_mule(b, 1'b0);
               end
               ENC_EUC_KR: begin
                  if (b[7]) hold_lead(KIND_KR, b);
                  else emit_mule(b, 1'b0);
               end
               ENC_EUC_CN: begin
                  if (b[7]) hold_lead(KIND_CN, b);
                  else emit_mule(b, 1'b0);
               end
               ENC_EUC_TW: begin
                  if (b == SS2) hold_lead(KIND_TW4, 8'h00);
                  else if (b[7]) hold_lead(KIND_TW2, b);
                  else emit_mule(b, 1'b0);
               end
               default: begin
                  // Latin-1 and the reserved codes
                  if (b > ASCII_MAX) emit_mule(LC_LATIN1, 1'b0);
                  emit_mule(b, 1'b0);
               end
            endcase
         end else begin
            // continuation of a held character
            c1   = lead_b;
            done = 1'b1;
            case (held_kind) inside
               KIND_SJIS: begin
                  hi = {1'b0, c1[5:0], 1'b0} + SJIS_HI_OF + {7'd0, (b > SJIS_SPLIT)};
                  lo = b + ((b > SJIS_SPLIT) ? SJIS_LO_A : SJIS_LO_B)
                       + {7'd0, (b < SJIS_GAP)};
                  emit_mule(LC_X0208, 1'b0);
                  emit_mule(hi, 1'b0);
                  emit_mule(lo, 1'b0);
               end
               KIND_KANA: begin
                  emit_mule(LC_KANA, 1'b0);
                  emit_mule(b, 1'b0);
               end
               KIND_X0212: begin
                  if (held_cnt == 2'd1) begin
                     lead_b   = b;
                     held_cnt = 2'd2;
                     done     = 1'b0;
                  end else begin
                     emit_mule(LC_X0212, 1'b0);
                     emit_mule(c1, 1'b0);
                     emit_mule(b, 1'b0);
                  end
               end
               KIND_X0208, KIND_KR, KIND_CN, KIND_TW2: begin
                  case (held_kind)
                     KIND_X0208: emit_mule(LC_X0208, 1'b0);
                     KIND_KR:    emit_mule(LC_KSC5601, 1'b0);
                     KIND_CN:    emit_mule(LC_GB2312, 1'b0);
                     default:    emit_mule(LC_CNS1, 1'b0);
                  endcase
                  emit_mule(c1, 1'b0);
                  emit_mule(b, 1'b0);
               end
               default: begin
                  // four byte CNS: SS2, plane, two code bytes
                  if (held_cnt == 2'd1) begin
                     lead_b   = b;
                     held_cnt = 2'd2;
                     done     = 1'b0;
                  end else if (held_cnt == 2'd2) begin
                     mid_b    = b;
                     held_cnt = 2'd3;
                     done     = 1'b0;
                  end else begin
                     if (c1 == PLANE1) emit_mule(LC_CNS1, 1'b0);
                     else if (c1 == PLANE2) emit_mule(LC_CNS2, 1'b0);
                     else begin
                        emit_mule(LC_PRIV, 1'b0);
                        emit_mule(c1 + PLANE_OFS, 1'b0);
                     end
                     emit_mule(mid_b, 1'b0);
                     emit_mule(b, 1'b0);
                  end
               end
            endcase
            if (done) held_cnt = 2'd0;
         end
      end
      // string end drops any partial character
      if (b == 8'h00 || last) begin
         clear_char();
         emit_mule(8'h00, 1'b1);
      end
      if (burst_q.size() > 0) burst_q[$].run_last = 1'b1;
      foreach (burst_q[i]) mule_exp_q.push_back(burst_q[i]);
   endtask

   // ------------------------------------------------------------------
   // request driver: one item per transfer, while req_idle a random gap before each item
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         convert_byte(req_ch.data_byte, req_ch.last_byte);
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin : req_driver
      logic         nxt_valid;
      logic [7:0]   nxt_data;
      logic         nxt_last;
      src_byte_type item;
      nxt_valid = req_ch.valid;
      nxt_data  = req_ch.data_byte;
      nxt_last  = req_ch.last_byte;
      if (reset) begin
         nxt_valid = 1'b0;
      end else begin
         if (req_taken) begin
            req_taken = 1'b0;
            nxt_valid = 1'b0;
         end
         if (!nxt_valid && pend_q.size() > 0) begin
            if (!gap_drawn) begin
               gap_left  = req_idle ? $urandom_range(0, MAX_IDLE) : 0;
               gap_drawn = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               item      = pend_q.pop_front();
               nxt_valid = 1'b1;
               nxt_data  = item.data;
               nxt_last  = item.last;
               gap_drawn = 1'b0;
            end
         end
      end
      req_ch.valid     <= nxt_valid;
      req_ch.data_byte <= nxt_data;
      req_ch.last_byte <= nxt_last;
   end

   // ------------------------------------------------------------------
   // result monitor: random stall before each transfer while rsp_idle, in-order check
   // ------------------------------------------------------------------
   always @(negedge clock) begin : rsp_stall
      logic nxt_ready;
      if (rsp_taken || !stall_drawn) begin
         stall_left  = rsp_idle ? $urandom_range(0, MAX_IDLE) : 0;
         stall_drawn = 1'b1;
         rsp_taken   = 1'b0;
      end
      if (stall_left > 0) begin
         stall_left--;
         nxt_ready = 1'b0;
      end else begin
         nxt_ready = 1'b1;
      end
      rsp_ch.ready <= nxt_ready;
   end

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         err_count++;
         $display("%t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      mule_byte_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_taken = 1'b1;
         if (mule_exp_q.size() == 0) begin
            err_count++;
            $display("%t: result with nothing expected, expected none actual %h/%b/%b",
                     $time, rsp_ch.mic_byte, rsp_ch.run_last, rsp_ch.string_end);
         end else begin
            want = mule_exp_q.pop_front();
            check_field("mic_byte", want.mic, rsp_ch.mic_byte);
            check_field("run_last", {7'd0, want.run_last}, {7'd0, rsp_ch.run_last});
            check_field("string_end", {7'd0, want.str_end}, {7'd0, rsp_ch.string_end});
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_byte(input logic [7:0] b, input logic last);
      pend_q.push_back('{data: b, last: last});
   endtask

   function automatic logic [7:0] trail_byte();
      if ($urandom_range(0, 3) != 0) return 8'($urandom_range(8'ha1, 8'hfe));
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] ascii_byte();
      return 8'($urandom_range(1, 8'h7f));
   endfunction

   // one well-formed character of the given encoding into char_bytes
   task automatic build_char(input encoding_type enc);
      logic [7:0] b;
      int         pick;
      char_bytes.delete();
      pick = $urandom_range(0, 9);
      case (enc)
         ENC_SJIS: begin
            if (pick < 2) char_bytes.push_back(ascii_byte());
            else if (pick < 4) char_bytes.push_back(8'($urandom_range(KANA_LO, KANA_HI)));
            else begin
               if ($urandom_range(0, 1)) b = 8'($urandom_range(8'h80, 8'ha0));
               else b = 8'($urandom_range(8'he0, 8'hff));
               char_bytes.push_back(b);
               char_bytes.push_back(8'($urandom_range(1, 255)));
            end
         end
         ENC_EUC_JP: begin
            if (pick < 2) char_bytes.push_back(ascii_byte());
            else if (pick < 4) begin
               char_bytes.push_back(SS2);
               char_bytes.push_back(trail_byte());
            end else if (pick < 6) begin
               char_bytes.push_back(SS3);
               char_bytes.push_back(trail_byte());
               char_bytes.push_back(trail_byte());
            end else begin
               b = 8'($urandom_range(8'h80, 8'hff));
               if (b == SS2 || b == SS3) b = 8'hb0;
               char_bytes.push_back(b);
               char_bytes.push_back(trail_byte());
            end
         end
         ENC_EUC_KR, ENC_EUC_CN: begin
            if (pick < 3) char_bytes.push_back(ascii_byte());
            else begin
               char_bytes.push_back(8'($urandom_range(8'h80, 8'hff)));
               char_bytes.push_back(trail_byte());
            end
         end
         ENC_EUC_TW: begin
            if (pick < 2) char_bytes.push_back(ascii_byte());
            else if (pick < 6) begin
               char_bytes.push_back(SS2);
               case ($urandom_range(0, 3))
                  0:       char_bytes.push_back(PLANE1);
                  1:       char_bytes.push_back(PLANE2);
                  2:       char_bytes.push_back(8'($urandom_range(8'ha3, 8'hb0)));
                  default: char_bytes.push_back(8'($urandom_range(1, 255)));
               endcase
               char_bytes.push_back(trail_byte());
               char_bytes.push_back(trail_byte());
            end else begin
               b = 8'($urandom_range(8'h80, 8'hff));
               if (b == SS2) b = 8'hc4;
               char_bytes.push_back(b);
               char_bytes.push_back(trail_byte());
            end
         end
         default: char_bytes.push_back(8'($urandom_range(1, 255)));
      endcase
   endtask

   // one string of well-formed characters with some noise and a random ending
   task automatic queue_string(input encoding_type enc, inout int sent);
      int n_chars;
      int ending;
      str_bytes.delete();
      n_chars = $urandom_range(1, 6);
      for (int i = 0; i < n_chars; i++) begin
         if ($urandom_range(0, 7) == 0) str_bytes.push_back(8'($urandom_range(0, 255)));
         build_char(enc);
         foreach (char_bytes[j]) str_bytes.push_back(char_bytes[j]);
      end
      ending = $urandom_range(0, 9);
      if (ending >= 8 && str_bytes.size() > 1) void'(str_bytes.pop_back());
      if (ending >= 5 && ending < 8) str_bytes.push_back(8'h00);
      foreach (str_bytes[i])
         queue_byte(str_bytes[i], (i == str_bytes.size() - 1) && (ending != 5));
      sent += str_bytes.size();
   endtask

   // everything sent and every result back, then let the pipe settle
   task automatic wait_all_done();
      while (pend_q.size() != 0 || req_ch.valid || mule_exp_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_encoding(input encoding_type enc);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= enc;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      enc_mode = enc;
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      encoding_type phase_order[9];
      logic [7:0]   carry_q[$];
      int           sent;
      phase_order = '{ENC_EUC_JP, ENC_EUC_KR, ENC_EUC_CN, ENC_EUC_TW, ENC_LATIN1,
                      ENC_RSVD6, ENC_RSVD7, ENC_SJIS, ENC_EUC_TW};
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = ENC_SJIS;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.last_byte = 1'b0;
      rsp_ch.ready     = 1'b0;
      enc_mode         = ENC_SJIS;
      clear_char();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: SJIS after reset
      queue_byte(8'h00, 1'b0);                          // empty string
      queue_byte(8'h41, 1'b0);
      queue_byte(8'h7f, 1'b0);
      queue_byte(8'ha1, 1'b0);                          // kana range edges
      queue_byte(8'hdf, 1'b0);
      queue_byte(8'h81, 1'b0); queue_byte(8'h40, 1'b0); // kanji, low trail
      queue_byte(8'h9f, 1'b0); queue_byte(8'h9f, 1'b0); // kanji, high trail
      queue_byte(8'hff, 1'b0); queue_byte(8'hff, 1'b0); // byte arithmetic wraps
      queue_byte(8'h80, 1'b0); queue_byte(8'h9e, 1'b0);
      queue_byte(8'he0, 1'b0); queue_byte(8'h00, 1'b0); // zero inside a character
      queue_byte(8'h81, 1'b1);                          // last byte is a lead
      queue_byte(8'h00, 1'b1);                          // last byte that is zero
      queue_byte(8'h20, 1'b1);
      queue_byte(8'h8e, 1'b0);                          // lead only, no result
      wait_all_done();
      // mode change mid-character: the kanji still completes as SJIS
      write_encoding(ENC_LATIN1);
      queue_byte(8'h40, 1'b0);
      queue_byte(8'h80, 1'b1);
      wait_all_done();

      // random phases, one encoding each
      foreach (phase_order[p]) begin
         write_encoding(phase_order[p]);
         if (p == 0) begin
            req_idle = 1'b0;
            rsp_idle = 1'b0;
         end else if (p == 1) begin
            req_idle = 1'b1;
            rsp_idle = 1'b1;
         end else begin
            req_idle = 1'($urandom_range(0, 1));
            rsp_idle = 1'($urandom_range(0, 1));
         end
         // finish a character left open by the previous phase
         while (carry_q.size() > 0) queue_byte(carry_q.pop_front(), 1'b0);
         sent = 0;
         while (sent < PHASE_BYTES) queue_string(phase_order[p], sent);
         // leave one character open across the next mode change
         build_char(phase_order[p]);
         for (int i = 0; i < char_bytes.size() - 1; i++) queue_byte(char_bytes[i], 1'b0);
         if (char_bytes.size() > 1) carry_q.push_back(char_bytes[$]);
         wait_all_done();
      end
      while (carry_q.size() > 0) queue_byte(carry_q.pop_front(), carry_q.size() == 1);
      wait_all_done();

      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/cjk_pkg.sv
hdl/cjk_if.sv
hdl/cjk_front.sv
hdl/cjk_queue.sv
hdl/cjk_back.sv
hdl/cjk_to_mule_internal_converter.sv
hdl/cjk_checker.sv
dv/cjk_to_mule_internal_converter_tb.sv
